@@ hw/rtl/rv32alu_pkg.sv @@
// rv32alu_pkg: shared constants, operation codes and the decoded word type
// for the register alu execute block
// no dependencies
package rv32alu_pkg;

  localparam int XLEN        = 32;
  localparam int MODE_W      = 4;
  localparam int IDX_W       = 5;
  localparam int REG_COUNT   = 32;
  localparam int REG_ADDR_W  = $clog2(REG_COUNT);
  localparam int SHAMT_W     = 5;
  localparam logic [XLEN-1:0] PC_STEP = XLEN'(4);

  localparam int QUEUE_DEPTH = 2;
  localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
  localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

  // operation codes, equal to the mode field encoding
  typedef enum logic [MODE_W-1:0] {
    OP_ADD  = 4'd0,
    OP_SUB  = 4'd1,
    OP_XOR  = 4'd2,
    OP_OR   = 4'd3,
    OP_AND  = 4'd4,
    OP_SLL  = 4'd5,
    OP_SRL  = 4'd6,
    OP_SRA  = 4'd7,
    OP_ADDI = 4'd8,
    OP_XORI = 4'd9,
    OP_ORI  = 4'd10,
    OP_ANDI = 4'd11,
    OP_LUI  = 4'd12,
    OP_NONE = 4'd13
  } op_t;

  // classified instruction word passed from front to back
  typedef struct packed {
    op_t              op;
    logic             we;
    logic [IDX_W-1:0] rd;
    logic [IDX_W-1:0] rs_a;
    logic [IDX_W-1:0] rs_b;
    logic             a_zero;
    logic             b_zero;
    logic [XLEN-1:0]  imm;
    logic [XLEN-1:0]  next_pc;
  } dec_t;

  // register index that always reads as zero
  function automatic logic idx_reads_zero(input logic [IDX_W-1:0] idx);
    logic out_of_range;
    out_of_range = ({1'b0, idx} >= (IDX_W+1)'(REG_COUNT));
    return (idx == '0) || out_of_range;
  endfunction

endpackage

@@ hw/rtl/rv32alu_if.sv @@
// rv32alu_in_if / rv32alu_out_if: valid/ready channels for instruction
// words and result words
// depends on rv32alu_pkg
interface rv32alu_in_if;
  import rv32alu_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [MODE_W-1:0]        mode;
  logic [IDX_W-1:0]         dest_index;
  logic [IDX_W-1:0]         source_a_index;
  logic [IDX_W-1:0]         source_b_index;
  logic signed [XLEN-1:0]   immediate;

  modport source (output valid, mode, dest_index, source_a_index, source_b_index,
                  immediate, input ready);
  modport sink   (input valid, mode, dest_index, source_a_index, source_b_index,
                  immediate, output ready);
endinterface

interface rv32alu_out_if;
  import rv32alu_pkg::*;
  logic             valid;
  logic             ready;
  logic             write_enable;
  logic [IDX_W-1:0] written_register;
  logic [XLEN-1:0]  written_value;
  logic [XLEN-1:0]  next_pc;

  modport source (output valid, write_enable, written_register, written_value, next_pc,
                  input ready);
  modport sink   (input valid, write_enable, written_register, written_value, next_pc,
                  output ready);
endinterface

@@ hw/rtl/rv32i_register_alu_execute.sv @@
// Executes one RV32I register-register, register-immediate or lui
// instruction per input word against a 32 x 32-bit register file and
// returns one result word per instruction, in order. Sustained rate is one
// word per cycle with both sides flowing; an accepted word passes through the
// queue, the register file read (a registered read port), then execute and
// write back, then the result word register, with a bypass so a dependent
// instruction may follow directly. The program counter starts at zero after
// reset and each result carries its value plus 4. Register zero and unused
// modes never write. The register file needs no clearing pass: per-register
// written flags make unwritten registers read as zero.
// depends on rv32alu_pkg, rv32alu_if, rv32alu_front, rv32alu_queue, rv32alu_back
module rv32i_register_alu_execute
  import rv32alu_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  rv32alu_in_if.sink    in_ch,
  rv32alu_out_if.source out_ch
);

  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;
  dec_t q_word;
  dec_t q_head;

  // accept and classify
  rv32alu_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_word (q_word)
  );

  // decoupling queue
  rv32alu_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_word (q_word),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  // execute and write back
  rv32alu_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_head  (q_head),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

@@ hw/rtl/rv32alu_ram.sv @@
// rv32alu_ram: generic ram, one write port, two registered read ports
// no dependencies
module rv32alu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // read ports, old data on a same-cycle write
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem_r[raddr_a];
      rdata_b <= mem_r[raddr_b];
    end
  end

endmodule

@@ hw/rtl/rv32alu_front.sv @@
// rv32alu_front: accepts instruction words, classifies the operation,
// qualifies the write and stamps the next program counter
// depends on rv32alu_pkg, rv32alu_if
module rv32alu_front
  import rv32alu_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  rv32alu_in_if.sink  in_ch,
  input  logic        q_full,
  output logic        q_push,
  output dec_t        q_word
);

  logic [XLEN-1:0] pc_r;
  logic [XLEN-1:0] pc_nxt;
  op_t             op;

  // accept whenever the queue has room
  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;
  assign pc_nxt      = pc_r + PC_STEP;

  // operation decode, unused modes become no-ops
  always_comb begin
    priority if (in_ch.mode <= OP_LUI) begin
      op = op_t'(in_ch.mode);
    end else begin
      op = OP_NONE;
    end
  end

  // classified word
  always_comb begin
    q_word.op      = op;
    q_word.we      = (op != OP_NONE) && !idx_reads_zero(in_ch.dest_index);
    q_word.rd      = in_ch.dest_index;
    q_word.rs_a    = in_ch.source_a_index;
    q_word.rs_b    = in_ch.source_b_index;
    q_word.a_zero  = idx_reads_zero(in_ch.source_a_index);
    q_word.b_zero  = idx_reads_zero(in_ch.source_b_index);
    q_word.imm     = XLEN'(in_ch.immediate);
    q_word.next_pc = pc_nxt;
  end

  // program counter advances once per accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= '0;
    end else if (q_push) begin
      pc_r <= pc_nxt;
    end
  end

endmodule

@@ hw/rtl/rv32alu_queue.sv @@
// rv32alu_queue: short fifo of classified words between front and back
// depends on rv32alu_pkg
module rv32alu_queue
  import rv32alu_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  dec_t push_word,
  output logic full,
  input  logic pop,
  output dec_t head,
  output logic empty
);

  dec_t               slot_r [QUEUE_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r;
  logic [Q_PTR_W-1:0] rd_ptr_r;
  logic [Q_CNT_W-1:0] cnt_r;
  logic [Q_PTR_W-1:0] wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_nxt;

  assign full  = (cnt_r == Q_CNT_W'(QUEUE_DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = slot_r[rd_ptr_r];

  // pointer wrap
  assign wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
  assign rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_word;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_nxt;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_nxt;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

@@ hw/rtl/rv32alu_back.sv @@
// rv32alu_back: issues words from the queue, reads the register file,
// executes the alu operation, writes back and holds the result word
// depends on rv32alu_pkg, rv32alu_if, rv32alu_ram
module rv32alu_back
  import rv32alu_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  dec_t          q_head,
  input  logic          q_empty,
  output logic          q_pop,
  rv32alu_out_if.source out_ch
);

  // execute stage
  logic            ex_vld_r;
  dec_t            ex_r;
  logic            fwd_a_r;
  logic            fwd_b_r;
  logic            vld_a_r;
  logic            vld_b_r;
  logic [XLEN-1:0] fwd_val_r;
  logic [REG_COUNT-1:0] reg_vld_r;

  // result word
  logic             out_vld_r;
  logic             out_we_r;
  logic [IDX_W-1:0] out_rd_r;
  logic [XLEN-1:0]  out_val_r;
  logic [XLEN-1:0]  out_pc_r;

  logic            ex_fire;
  logic            issue;
  logic            wr_en;
  logic [XLEN-1:0] ram_a;
  logic [XLEN-1:0] ram_b;
  logic [XLEN-1:0] opd_a;
  logic [XLEN-1:0] opd_b;
  logic [SHAMT_W-1:0] shamt;
  logic [XLEN-1:0] result;

  assign ex_fire = ex_vld_r && (!out_vld_r || out_ch.ready);
  assign issue   = !q_empty && (!ex_vld_r || ex_fire);
  assign q_pop   = issue;
  assign wr_en   = ex_fire && ex_r.we;

  rv32alu_ram #(
    .WIDTH (XLEN),
    .DEPTH (REG_COUNT)
  ) u_regfile (
    .clk     (clk),
    .we      (wr_en),
    .waddr   (ex_r.rd[REG_ADDR_W-1:0]),
    .wdata   (result),
    .re      (issue),
    .raddr_a (q_head.rs_a[REG_ADDR_W-1:0]),
    .raddr_b (q_head.rs_b[REG_ADDR_W-1:0]),
    .rdata_a (ram_a),
    .rdata_b (ram_b)
  );

  // issue: capture word, written flags and bypass from the retiring word
  always_ff @(posedge clk) begin
    if (issue) begin
      ex_r      <= q_head;
      vld_a_r   <= reg_vld_r[q_head.rs_a[REG_ADDR_W-1:0]];
      vld_b_r   <= reg_vld_r[q_head.rs_b[REG_ADDR_W-1:0]];
      fwd_a_r   <= wr_en && (ex_r.rd == q_head.rs_a);
      fwd_b_r   <= wr_en && (ex_r.rd == q_head.rs_b);
      fwd_val_r <= result;
    end
  end

  // operand select: zero register, bypass, never written, or ram
  always_comb begin
    priority if (ex_r.a_zero) begin
      opd_a = '0;
    end else if (fwd_a_r) begin
      opd_a = fwd_val_r;
    end else if (vld_a_r) begin
      opd_a = ram_a;
    end else begin
      opd_a = '0;
    end
    priority if (ex_r.b_zero) begin
      opd_b = '0;
    end else if (fwd_b_r) begin
      opd_b = fwd_val_r;
    end else if (vld_b_r) begin
      opd_b = ram_b;
    end else begin
      opd_b = '0;
    end
  end

  assign shamt = opd_b[SHAMT_W-1:0];

  // alu
  always_comb begin
    unique case (ex_r.op)
      OP_ADD:  result = opd_a + opd_b;
      OP_SUB:  result = opd_a - opd_b;
      OP_XOR:  result = opd_a ^ opd_b;
      OP_OR:   result = opd_a | opd_b;
      OP_AND:  result = opd_a & opd_b;
      OP_SLL:  result = opd_a << shamt;
      OP_SRL:  result = opd_a >> shamt;
      OP_SRA:  result = XLEN'($signed(opd_a) >>> shamt);
      OP_ADDI: result = opd_a + ex_r.imm;
      OP_XORI: result = opd_a ^ ex_r.imm;
      OP_ORI:  result = opd_a | ex_r.imm;
      OP_ANDI: result = opd_a & ex_r.imm;
      OP_LUI:  result = ex_r.imm;
      OP_NONE: result = '0;
      default: result = '0;
    endcase
  end

  // stage valids and register written flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ex_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      reg_vld_r <= '0;
    end else begin
      if (issue) begin
        ex_vld_r <= 1'b1;
      end else if (ex_fire) begin
        ex_vld_r <= 1'b0;
      end
      if (ex_fire) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
      if (wr_en) begin
        reg_vld_r[ex_r.rd[REG_ADDR_W-1:0]] <= 1'b1;
      end
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    if (ex_fire) begin
      out_we_r  <= ex_r.we;
      out_rd_r  <= ex_r.we ? ex_r.rd : '0;
      out_val_r <= result;
      out_pc_r  <= ex_r.next_pc;
    end
  end

  assign out_ch.valid            = out_vld_r;
  assign out_ch.write_enable     = out_we_r;
  assign out_ch.written_register = out_rd_r;
  assign out_ch.written_value    = out_val_r;
  assign out_ch.next_pc          = out_pc_r;

endmodule

@@ hw/rtl/rv32alu_checker.sv @@
// rv32alu_checker: assertions on the result channel of the execute block,
// bound to the top level
// depends on rv32alu_pkg, rv32i_register_alu_execute
module rv32alu_checker
  import rv32alu_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_ready,
  input logic             out_write_enable,
  input logic [IDX_W-1:0] out_written_register,
  input logic [XLEN-1:0]  out_next_pc
);

  logic            out_fire;
  logic [XLEN-1:0] exp_pc_r;

  assign out_fire = out_valid && out_ready;

  // expected program counter of the next delivered word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_pc_r <= PC_STEP;
    end else if (out_fire) begin
      exp_pc_r <= exp_pc_r + PC_STEP;
    end
  end

  // a write never targets register zero
  a_we_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_write_enable |-> out_written_register != '0)
    else $error("write reported to register zero");

  // no write reports register zero
  a_nowe_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_write_enable |-> out_written_register == '0)
    else $error("written_register nonzero without write");

  // words come out in order, one pc step apart
  a_pc_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire |-> out_next_pc == exp_pc_r)
    else $error("result word out of order, lost or repeated");

  // stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_next_pc))
    else $error("stalled result word changed");

endmodule

bind rv32i_register_alu_execute rv32alu_checker u_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .out_valid            (out_ch.valid),
  .out_ready            (out_ch.ready),
  .out_write_enable     (out_ch.write_enable),
  .out_written_register (out_ch.written_register),
  .out_next_pc          (out_ch.next_pc)
);

@@ bench/rv32i_register_alu_execute_tb.sv @@
// rv32i_register_alu_execute_tb: random and directed check of the register alu
// execute block against an in-bench model of the register file and pc
// depends on rv32alu_pkg, rv32alu_if and rv32i_register_alu_execute
module rv32i_register_alu_execute_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rv32alu_pkg::*;

  localparam int RANDOM_WORDS    = 750;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int HOLD_AFTER      = 300;
  localparam int DRAIN_CYCLES    = 16;
  localparam int PRINT_CAP       = 60;

  // modes past lui that do nothing but advance the pc
  localparam logic [MODE_W-1:0] MODE_SPARE_A = MODE_W'(OP_NONE + 1);
  localparam logic [MODE_W-1:0] MODE_SPARE_B = MODE_W'(OP_NONE + 2);

  typedef struct {
    logic [MODE_W-1:0] mode;
    logic [IDX_W-1:0]  rd;
    logic [IDX_W-1:0]  rs_a;
    logic [IDX_W-1:0]  rs_b;
    logic [XLEN-1:0]   imm;
  } instr_t;

  typedef struct {
    logic             we;
    logic [IDX_W-1:0] rd;
    logic [XLEN-1:0]  value;
    logic [XLEN-1:0]  next_pc;
  } writeback_t;

  logic clk;
  logic rst_n;
  logic hold_rx;
  logic [31:0] cycle_count;

  rv32alu_in_if  in_ch();
  rv32alu_out_if out_ch();

  rv32i_register_alu_execute dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  instr_t     program_queue[$];
  writeback_t writeback_queue[$];
  instr_t     issue_word;
  logic [XLEN-1:0] arch_regs[REG_COUNT];
  logic [XLEN-1:0] arch_pc;
  int accepted_count;
  int mismatch_count;
  int issue_gap;
  int rx_stall;

  // no idling on either side for one stretch in every four
  wire calm = (cycle_count[9:8] == 2'b00);

  always #2 clk = ~clk;

  // free-running cycle count and run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // idle length: mostly none or short, now and then long
  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [XLEN-1:0] read_arch(input logic [IDX_W-1:0] idx);
    if (idx == '0 || idx >= REG_COUNT) return '0;
    return arch_regs[idx];
  endfunction

  // execute one instruction on the shadow state, return its writeback word
  function automatic writeback_t execute_instr(input instr_t w);
    logic [XLEN-1:0]    a;
    logic [XLEN-1:0]    b;
    logic [XLEN-1:0]    val;
    logic [SHAMT_W-1:0] sh;
    logic               known;
    writeback_t         r;
    a = read_arch(w.rs_a);
    b = read_arch(w.rs_b);
    sh = b[SHAMT_W-1:0];
    known = 1'b1;
    case (w.mode)
      OP_ADD:  val = a + b;
      OP_SUB:  val = a - b;
      OP_XOR:  val = a ^ b;
      OP_OR:   val = a | b;
      OP_AND:  val = a & b;
      OP_SLL:  val = a << sh;
      OP_SRL:  val = a >> sh;
      OP_SRA:  val = $signed(a) >>> sh;
      OP_ADDI: val = a + w.imm;
      OP_XORI: val = a ^ w.imm;
      OP_ORI:  val = a | w.imm;
      OP_ANDI: val = a & w.imm;
      OP_LUI:  val = w.imm;
      default: begin
        val = '0;
        known = 1'b0;
      end
    endcase
    r.we = known && (w.rd != '0) && (w.rd < REG_COUNT);
    if (r.we) arch_regs[w.rd] = val;
    arch_pc = arch_pc + PC_STEP;
    r.rd = r.we ? w.rd : '0;
    r.value = val;
    r.next_pc = arch_pc;
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input logic [XLEN-1:0] got,
                               input logic [XLEN-1:0] want);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP)
      $display("[%0t] %s: got %h want %h", $realtime, what, got, want);
  endtask

  task automatic queue_instr(input logic [MODE_W-1:0] mode, input logic [IDX_W-1:0] rd,
                             input logic [IDX_W-1:0] ra, input logic [IDX_W-1:0] rb,
                             input logic [XLEN-1:0] imm);
    instr_t w;
    w.mode = mode;
    w.rd = rd;
    w.rs_a = ra;
    w.rs_b = rb;
    w.imm = imm;
    program_queue.push_back(w);
  endtask

  // immediate: extremes, 12-bit with upper bits all zero or all one, or any 32-bit value
  function automatic logic [XLEN-1:0] pick_imm();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      case ($urandom_range(0, 3))
        0: return 32'h0000_0000;
        1: return 32'hFFFF_FFFF;
        2: return 32'h8000_0000;
        default: return 32'h7FFF_FFFF;
      endcase
    end
    if (r < 50) return {{20{1'b0}}, 12'($urandom)} ^ (($urandom_range(0, 1) != 0) ?
                       32'hFFFF_F000 : 32'h0);
    return $urandom;
  endfunction

  // word driver: holds a word until taken, then may idle before the next
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        writeback_queue.push_back(execute_instr(issue_word));
        accepted_count++;
      end
      if (in_ch.valid && !in_ch.ready) begin
        // word still on offer
      end else if (issue_gap > 0) begin
        issue_gap--;
        in_ch.valid <= 1'b0;
      end else if (program_queue.size() > 0) begin
        issue_word = program_queue.pop_front();
        in_ch.valid          <= 1'b1;
        in_ch.mode           <= issue_word.mode;
        in_ch.dest_index     <= issue_word.rd;
        in_ch.source_a_index <= issue_word.rs_a;
        in_ch.source_b_index <= issue_word.rs_b;
        in_ch.immediate      <= issue_word.imm;
        issue_gap = calm ? 0 : pick_idle();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk) begin
    writeback_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (writeback_queue.size() == 0) begin
          flag_mismatch("unexpected word, value", out_ch.written_value, '0);
        end else begin
          want = writeback_queue.pop_front();
          if (out_ch.write_enable !== want.we)
            flag_mismatch("write_enable", XLEN'(out_ch.write_enable), XLEN'(want.we));
          if (out_ch.written_register !== want.rd)
            flag_mismatch("written_register", XLEN'(out_ch.written_register),
                          XLEN'(want.rd));
          if (out_ch.written_value !== want.value)
            flag_mismatch("written_value", out_ch.written_value, want.value);
          if (out_ch.next_pc !== want.next_pc)
            flag_mismatch("next_pc", out_ch.next_pc, want.next_pc);
        end
      end
      if (hold_rx) begin
        out_ch.ready <= 1'b0;
      end else if (rx_stall > 0) begin
        rx_stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (!calm && $urandom_range(0, 3) == 0) rx_stall = pick_idle();
      end
    end
  end

  // one long receiver hold-off so the block backs up and stalls its input
  initial begin
    while (accepted_count < HOLD_AFTER) @(negedge clk);
    hold_rx <= 1'b1;
    repeat (HOLD_OFF_CYCLES) @(negedge clk);
    hold_rx <= 1'b0;
  end

  initial begin
    logic [IDX_W-1:0] last_rd;
    logic [MODE_W-1:0] mode;
    instr_t w;
    clk = 1'b0;
    rst_n = 1'b0;
    hold_rx = 1'b0;
    cycle_count = '0;
    accepted_count = 0;
    mismatch_count = 0;
    issue_gap = 0;
    rx_stall = 0;
    arch_pc = '0;
    for (int i = 0; i < REG_COUNT; i++) arch_regs[i] = '0;
    in_ch.valid = 1'b0;
    in_ch.mode = '0;
    in_ch.dest_index = '0;
    in_ch.source_a_index = '0;
    in_ch.source_b_index = '0;
    in_ch.immediate = '0;
    out_ch.ready = 1'b0;

    // directed: operand extremes, every operation, x0, odd shift amounts, spare modes
    queue_instr(OP_LUI,  5'd1,  5'd0,  5'd0,  32'hFFFF_FFFF);
    queue_instr(OP_LUI,  5'd2,  5'd0,  5'd0,  32'h8000_0000);
    queue_instr(OP_ADDI, 5'd3,  5'd0,  5'd0,  32'h7FFF_FFFF);
    queue_instr(OP_ADDI, 5'd4,  5'd0,  5'd0,  32'd31);
    queue_instr(OP_ADDI, 5'd5,  5'd0,  5'd0,  32'd37);
    queue_instr(OP_ADD,  5'd6,  5'd1,  5'd2,  32'h0);
    queue_instr(OP_SUB,  5'd7,  5'd0,  5'd1,  32'h0);
    queue_instr(OP_SUB,  5'd8,  5'd2,  5'd7,  32'h0);
    queue_instr(OP_XOR,  5'd9,  5'd1,  5'd3,  32'h0);
    queue_instr(OP_OR,   5'd10, 5'd2,  5'd3,  32'h0);
    queue_instr(OP_AND,  5'd11, 5'd1,  5'd2,  32'h0);
    queue_instr(OP_SLL,  5'd12, 5'd1,  5'd4,  32'h0);
    queue_instr(OP_SRL,  5'd13, 5'd2,  5'd4,  32'h0);
    queue_instr(OP_SRA,  5'd14, 5'd2,  5'd4,  32'h0);
    queue_instr(OP_SRA,  5'd15, 5'd1,  5'd5,  32'h0);
    queue_instr(OP_SLL,  5'd16, 5'd3,  5'd5,  32'h0);
    queue_instr(OP_ADDI, 5'd17, 5'd3,  5'd0,  32'h1);
    queue_instr(OP_XORI, 5'd18, 5'd2,  5'd0,  32'hFFFF_FFFF);
    queue_instr(OP_ORI,  5'd19, 5'd0,  5'd0,  32'h8000_0000);
    queue_instr(OP_ANDI, 5'd20, 5'd1,  5'd0,  32'h7FFF_FFFF);
    queue_instr(OP_ADD,  5'd0,  5'd1,  5'd1,  32'h0);
    queue_instr(OP_NONE,     5'd21, 5'd1, 5'd2, 32'hFFFF_FFFF);
    queue_instr(MODE_SPARE_A, 5'd22, 5'd3, 5'd4, 32'h1234_5678);
    queue_instr(MODE_SPARE_B, 5'd31, 5'd31, 5'd31, 32'h8000_0000);
    queue_instr(OP_ADDI, 5'd31, 5'd31, 5'd0,  32'hFFFF_FFFF);

    // random: chained dependencies, mostly valid modes, some spare ones
    last_rd = 5'd31;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if ($urandom_range(0, 99) < 6) mode = MODE_W'($urandom_range(OP_NONE, MODE_SPARE_B));
      else if ($urandom_range(0, 99) < 15) mode = OP_LUI;
      else mode = MODE_W'($urandom_range(OP_ADD, OP_ANDI));
      w.mode = mode;
      w.rd = IDX_W'($urandom_range(0, 31));
      w.rs_a = ($urandom_range(0, 2) == 0) ? last_rd : IDX_W'($urandom_range(0, 31));
      w.rs_b = ($urandom_range(0, 3) == 0) ? last_rd : IDX_W'($urandom_range(0, 31));
      w.imm = pick_imm();
      program_queue.push_back(w);
      last_rd = w.rd;
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // drain: all words sent and every writeback seen
    @(negedge clk);
    while (program_queue.size() > 0 || in_ch.valid || writeback_queue.size() > 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatch_count == 0 && writeback_queue.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
